>>> rtl/core/bawd_pkg.sv
// ----------------------------------------------------------------------------
// bawd_pkg
// Shared types and constants for the bus area decode and wait-count block.
// ----------------------------------------------------------------------------
package bawd_pkg;

   localparam int ADDR_W      = 32;
   localparam int ADDR_BITS   = 28;  // decoded address span
   localparam int KIND_W      = 2;
   localparam int WIDTH_W     = 4;
   localparam int AREA_W      = 5;
   localparam int WAIT_W      = 5;
   localparam int FAULT_W     = 2;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 4;

   localparam logic [ADDR_BITS-1:0] AREA6_NARROW_LIMIT = 28'h0380000;

   // access kinds
   localparam logic [KIND_W-1:0] KIND_INTERNAL = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ     = 2'd1;

   // fault codes
   localparam logic [FAULT_W-1:0] FAULT_OK    = 2'd0;
   localparam logic [FAULT_W-1:0] FAULT_ALIGN = 2'd1;
   localparam logic [FAULT_W-1:0] FAULT_WIDTH = 2'd2;

   // first external area and the highest area in the map
   localparam logic [AREA_W-1:0] AREA_FIRST_EXT = 5'd4;
   localparam logic [AREA_W-1:0] AREA_LAST      = 5'd18;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_GRP_A5   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRP_A6   = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRP_A8   = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRP_A10  = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRP_A12  = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRP_A14  = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRP_A16  = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRP_A18  = 4'd7;

   localparam logic [3:0] GRP_CFG_RESET  = 4'd7;
   localparam logic [2:0] GRP_WAIT_RESET = 3'd7;

   // bit 3: eight-bit device, bits 2-0: wait cycles
   typedef struct packed {
      logic [3:0] a5;
      logic [2:0] a6_wait;
      logic [3:0] a8;
      logic [3:0] a10;
      logic [3:0] a12;
      logic [3:0] a14;
      logic [3:0] a16;
      logic [3:0] a18;
   } grp_cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0]  req_type;
      logic [ADDR_W-1:0]  address;
      logic [WIDTH_W-1:0] width_bytes;
   } access_type;

   typedef struct packed {
      logic [FAULT_W-1:0] fault_code;
      logic [WAIT_W-1:0]  wait_cycles;
      logic [AREA_W-1:0]  area_number;
   } result_type;

endpackage

>>> rtl/core/bawd_decode.sv
// ----------------------------------------------------------------------------
// bawd_decode
// Checks one access, maps its address to an area and counts wait cycles.
// ----------------------------------------------------------------------------
module bawd_decode
   import bawd_pkg::*;
(
   input  access_type  acc,
   input  grp_cfg_type cfg,
   output result_type  res
);

   logic [ADDR_BITS-1:0] addr;
   logic [3:0]           top;
   logic [3:0]           mid;
   logic [3:0]           lo;
   logic                 w1;
   logic                 w2;
   logic                 w4;
   logic                 misaligned;
   logic [AREA_W-1:0]    area;
   logic [2:0]           wt;
   logic                 narrow;
   logic [1:0]           shift;
   logic [WAIT_W-1:0]    scaled;
   logic [WAIT_W-1:0]    wait_cnt;

   assign addr = acc.address[ADDR_BITS-1:0];
   assign top  = addr[27:24];
   assign mid  = addr[23:20];
   assign lo   = addr[19:16];
   assign w1   = (acc.width_bytes == 4'd1);
   assign w2   = (acc.width_bytes == 4'd2);
   assign w4   = (acc.width_bytes == 4'd4);
   assign misaligned = (w2 && acc.address[0]) || (w4 && (acc.address[1:0] != 2'b00));

   // area map
   always_comb begin
      case (top)
         4'h0: begin
            case (mid)
               4'h0: begin
                  if (lo < 4'd3)      area = 5'd0;
                  else if (lo < 4'd6) area = 5'd1;
                  else if (lo < 4'd8) area = 5'd2;
                  else                area = 5'd3;
               end
               4'h1:       area = 5'd4;
               4'h2:       area = 5'd5;
               4'h3:       area = 5'd6;
               4'h4, 4'h5: area = 5'd7;
               4'h6, 4'h7: area = 5'd8;
               4'h8, 4'h9, 4'hA, 4'hB: area = 5'd9;
               default:    area = 5'd10;
            endcase
         end
         4'h1:       area = mid[3] ? 5'd12 : 5'd11;
         4'h2:       area = 5'd13;
         4'h3:       area = 5'd14;
         4'h4, 4'h5: area = 5'd15;
         4'h6, 4'h7: area = 5'd16;
         4'h8, 4'h9, 4'hA, 4'hB: area = 5'd17;
         default:    area = AREA_LAST;
      endcase
   end

   // group settings; area 6 takes its device width from the address
   always_comb begin
      case (area)
         5'd4, 5'd5: begin
            wt = cfg.a5[2:0];  narrow = cfg.a5[3];
         end
         5'd6: begin
            wt = cfg.a6_wait;  narrow = (addr < AREA6_NARROW_LIMIT);
         end
         5'd7, 5'd8: begin
            wt = cfg.a8[2:0];  narrow = cfg.a8[3];
         end
         5'd9, 5'd10: begin
            wt = cfg.a10[2:0]; narrow = cfg.a10[3];
         end
         5'd11, 5'd12: begin
            wt = cfg.a12[2:0]; narrow = cfg.a12[3];
         end
         5'd13, 5'd14: begin
            wt = cfg.a14[2:0]; narrow = cfg.a14[3];
         end
         5'd15, 5'd16: begin
            wt = cfg.a16[2:0]; narrow = cfg.a16[3];
         end
         default: begin
            wt = cfg.a18[2:0]; narrow = cfg.a18[3];
         end
      endcase
   end

   // scale by width: an eight-bit device pays per byte, a 16-bit one per half-word
   always_comb begin
      if (narrow) shift = w4 ? 2'd2 : (w2 ? 2'd1 : 2'd0);
      else        shift = w4 ? 2'd1 : 2'd0;
      scaled = {2'b00, wt} << shift;
      if ((acc.req_type == KIND_INTERNAL) || (area < AREA_FIRST_EXT))
         wait_cnt = '0;
      else
         wait_cnt = scaled + ((acc.req_type == KIND_READ) ? 5'd1 : 5'd2);
   end

   always_comb begin
      res.area_number = area;
      res.wait_cycles = wait_cnt;
      res.fault_code  = FAULT_OK;
      if (!(w1 || w2 || w4)) begin
         res.area_number = '0;
         res.wait_cycles = '0;
         res.fault_code  = FAULT_WIDTH;
      end else if (misaligned) begin
         res.area_number = '0;
         res.wait_cycles = '0;
         res.fault_code  = FAULT_ALIGN;
      end
   end

endmodule

>>> rtl/core/bus_area_decode_wait_top.sv
// ----------------------------------------------------------------------------
// bus_area_decode_wait_top
// Bus area decode and wait-cycle count, one access per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one access per transaction: tuser holds the access kind,
//   tdata the address and the width in bytes. rsp_* returns one result per
//   access: area number, extra wait cycles and fault code.
//   csr_* writes the area group settings; write only while no transaction is
//   in flight. Indexes above the last register are ignored.
// Pipeline and throughput:
//   the input register takes an accepted request, then the decode logic
//   loads the result register once the output is not stalled, and
//   rsp_tvalid rises. One transaction per cycle is sustained while
//   rsp_tready stays high; the rate is set by the single decode pass.
// Reset:
//   Both pipeline stages empty; all group settings return to 7.
// Stall:
//   While rsp_tready is low the result holds; the input register still
//   takes one more request, then req_tready drops until the result drains.
// ----------------------------------------------------------------------------
module bus_area_decode_wait_top
   import bawd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [39:0]            req_tdata,   // address[31:0], width_bytes[35:32], zero fill
   input  logic [KIND_W-1:0]      req_tuser,   // req_type[1:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [15:0]            rsp_tdata,   // area_number[4:0], wait_cycles[9:5],
                                               // fault_code[11:10], zero fill
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   grp_cfg_type cfg_ff;
   grp_cfg_type cfg_in;

   logic       s1_valid_ff;
   logic       s1_valid_in;
   access_type s1_acc_ff;
   access_type s1_acc_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_res_ff;
   result_type out_res_in;
   result_type dec_res;
   logic       out_stall;
   logic       s1_move;
   logic       req_take;

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GRP_A5:  cfg_in.a5      = csr_wdata;
            CSR_GRP_A6:  cfg_in.a6_wait = csr_wdata[2:0];
            CSR_GRP_A8:  cfg_in.a8      = csr_wdata;
            CSR_GRP_A10: cfg_in.a10     = csr_wdata;
            CSR_GRP_A12: cfg_in.a12     = csr_wdata;
            CSR_GRP_A14: cfg_in.a14     = csr_wdata;
            CSR_GRP_A16: cfg_in.a16     = csr_wdata;
            CSR_GRP_A18: cfg_in.a18     = csr_wdata;
            default:     cfg_in         = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{a5: GRP_CFG_RESET, a6_wait: GRP_WAIT_RESET, a8: GRP_CFG_RESET,
                     a10: GRP_CFG_RESET, a12: GRP_CFG_RESET, a14: GRP_CFG_RESET,
                     a16: GRP_CFG_RESET, a18: GRP_CFG_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline control
   assign out_stall  = out_valid_ff && !rsp_tready;
   assign s1_move    = s1_valid_ff && !out_stall;
   assign req_tready = !s1_valid_ff || !out_stall;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in  = req_take || (s1_valid_ff && out_stall);
      s1_acc_in    = s1_acc_ff;
      if (req_take) begin
         s1_acc_in.req_type    = req_tuser;
         s1_acc_in.address     = req_tdata[31:0];
         s1_acc_in.width_bytes = req_tdata[35:32];
      end
      out_valid_in = s1_move || out_stall;
      out_res_in   = s1_move ? dec_res : out_res_ff;
   end

   bawd_decode u_decode (
      .acc (s1_acc_ff),
      .cfg (cfg_ff),
      .res (dec_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_acc_ff  <= s1_acc_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_res_ff};

   // a faulted access carries no area and no wait
   a_fault_clears : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (out_res_ff.fault_code != FAULT_OK)) |->
      ((out_res_ff.area_number == '0) && (out_res_ff.wait_cycles == '0)))
      else $error("faulted result carries area or wait");

   a_area_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_res_ff.area_number <= AREA_LAST))
      else $error("area number out of range");

   // internal areas never add wait
   a_internal_no_wait : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (out_res_ff.area_number < AREA_FIRST_EXT)) |->
      (out_res_ff.wait_cycles == '0))
      else $error("wait on an internal area");

   // back-pressure only when both stages are full and the output is held
   a_ready_only_when_full : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && rsp_tvalid && !rsp_tready))
      else $error("request side stalled without a full pipeline");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !s1_valid_ff))
      else $error("pipeline not empty after reset");

endmodule

>>> tb/tb_bus_area_decode_wait_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_bus_area_decode_wait_top
// Self-checking bench for the bus area decode and wait-count block. A short
// table of hand-picked accesses runs under the reset settings. Random
// accesses then run under several group settings. Every result is compared,
// in order of acceptance, with a typed-in result or a local decode of the access.
// ---------------------------------------------------------------------------
module tb_bus_area_decode_wait_top;
   import bawd_pkg::*;

   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;  // no meaning, decodes as a write
   localparam logic [AREA_W-1:0] AREA_SPLIT = 5'd6;  // width taken from the address
   localparam int N_GROUPS        = 8;
   localparam int N_INDEXES       = 2 ** CSR_INDEX_W;
   localparam int N_PROBES        = 27;
   localparam int N_PHASES        = 6;
   localparam int RANDOM_ACCESSES = 1550;
   localparam int DRAIN_CYCLES    = 6;
   localparam int CYCLE_LIMIT     = 200000;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [ADDR_W-1:0]  addr;
      logic [WIDTH_W-1:0] width;
      logic               known;  // result typed in below, else decoded locally
      result_type         res;    // fault, wait, area
   } probe_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [39:0]            req_tdata  = '0;  // address[31:0], width_bytes[35:32], zero fill
   logic [KIND_W-1:0]      req_tuser  = '0;  // req_type[1:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [15:0]            rsp_tdata;        // area_number[4:0], wait_cycles[9:5],
                                             // fault_code[11:10], zero fill
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   logic [3:0]  grp_setting [N_GROUPS];
   result_type  pending_decodes [$];
   int unsigned mismatches  = 0;
   int unsigned cycle_count = 0;
   logic        steady      = 1'b0;

   probe_type probes [N_PROBES] = '{
      '{KIND_INTERNAL, 32'h0000_0000, 4'd1,  1'b1, '{FAULT_OK,    5'd0,  5'd0}},
      '{KIND_READ,     32'h0FFF_FFFF, 4'd1,  1'b1, '{FAULT_OK,    5'd8,  5'd18}},
      '{KIND_WRITE,    32'hFFFF_FFFC, 4'd4,  1'b1, '{FAULT_OK,    5'd16, 5'd18}},
      '{KIND_INTERNAL, 32'hF000_0000, 4'd4,  1'b1, '{FAULT_OK,    5'd0,  5'd0}},
      '{KIND_READ,     32'h0010_0000, 4'd0,  1'b1, '{FAULT_WIDTH, 5'd0,  5'd0}},
      '{KIND_WRITE,    32'h0010_0000, 4'd15, 1'b1, '{FAULT_WIDTH, 5'd0,  5'd0}},
      '{KIND_READ,     32'h0000_0003, 4'd3,  1'b1, '{FAULT_WIDTH, 5'd0,  5'd0}},
      '{KIND_WRITE,    32'h0000_0000, 4'd8,  1'b1, '{FAULT_WIDTH, 5'd0,  5'd0}},
      '{KIND_READ,     32'h0000_0001, 4'd2,  1'b1, '{FAULT_ALIGN, 5'd0,  5'd0}},
      '{KIND_WRITE,    32'h0010_0002, 4'd4,  1'b1, '{FAULT_ALIGN, 5'd0,  5'd0}},
      '{KIND_SPARE,    32'hFFFF_FFFF, 4'd4,  1'b1, '{FAULT_ALIGN, 5'd0,  5'd0}},
      '{KIND_READ,     32'hFFFF_FFFF, 4'd2,  1'b1, '{FAULT_ALIGN, 5'd0,  5'd0}},
      '{KIND_READ,     32'h0002_FFFF, 4'd1,  1'b0, '0},
      '{KIND_WRITE,    32'h0003_0000, 4'd2,  1'b0, '0},
      '{KIND_READ,     32'h0006_0000, 4'd4,  1'b0, '0},
      '{KIND_WRITE,    32'h000F_FFFC, 4'd4,  1'b0, '0},
      '{KIND_SPARE,    32'h0010_0000, 4'd1,  1'b0, '0},
      '{KIND_READ,     32'h002F_FFFE, 4'd2,  1'b0, '0},
      '{KIND_READ,     32'h0030_0000, 4'd4,  1'b0, '0},
      '{KIND_WRITE,    32'h0038_0000, 4'd4,  1'b0, '0},
      '{KIND_READ,     32'h0040_0000, 4'd2,  1'b0, '0},
      '{KIND_WRITE,    32'h0070_0000, 4'd1,  1'b0, '0},
      '{KIND_READ,     32'h00B0_0000, 4'd4,  1'b0, '0},
      '{KIND_WRITE,    32'h00C0_0000, 4'd2,  1'b0, '0},
      '{KIND_READ,     32'h017F_FFFC, 4'd4,  1'b0, '0},
      '{KIND_WRITE,    32'h0180_0000, 4'd4,  1'b0, '0},
      '{KIND_INTERNAL, 32'h0200_0000, 4'd1,  1'b0, '0}
   };

   bus_area_decode_wait_top DUT (.*);

   always #6 clock = ~clock;

   function automatic result_type decode_access(input access_type acc);
      result_type             r;
      logic [ADDR_BITS-1:0]   a;
      logic [3:0]             top, mid, lo, setting;
      logic [AREA_W-1:0]      area;
      logic [CSR_INDEX_W-1:0] grp;
      logic                   narrow;
      logic [2:0]             wt;
      logic [WAIT_W-1:0]      scaled;
      r = '0;
      r.fault_code = FAULT_OK;
      if (acc.width_bytes != 4'd1 && acc.width_bytes != 4'd2 && acc.width_bytes != 4'd4) begin
         r.fault_code = FAULT_WIDTH;
         return r;
      end
      if ((acc.width_bytes == 4'd2 && acc.address[0]) ||
          (acc.width_bytes == 4'd4 && acc.address[1:0] != 2'b00)) begin
         r.fault_code = FAULT_ALIGN;
         return r;
      end
      a   = acc.address[ADDR_BITS-1:0];
      top = a[27:24];
      mid = a[23:20];
      lo  = a[19:16];
      if (top == 4'h0) begin
         if (mid == 4'h0)
            area = (lo < 4'h3) ? 5'd0 : (lo < 4'h6) ? 5'd1 : (lo < 4'h8) ? 5'd2 : 5'd3;
         else if (mid < 4'h4) area = 5'(mid) + 5'd3;
         else if (mid < 4'h6) area = 5'd7;
         else if (mid < 4'h8) area = 5'd8;
         else if (mid < 4'hC) area = 5'd9;
         else area = 5'd10;
      end else if (top == 4'h1) area = mid[3] ? 5'd12 : 5'd11;
      else if (top < 4'h4) area = 5'(top) + 5'd11;
      else if (top < 4'h6) area = 5'd15;
      else if (top < 4'h8) area = 5'd16;
      else if (top < 4'hC) area = 5'd17;
      else area = 5'd18;
      r.area_number = area;

      // internal areas and internal kinds add nothing
      if (area >= AREA_FIRST_EXT && acc.req_type != KIND_INTERNAL) begin
         if (area == AREA_SPLIT) begin
            narrow = (a < AREA6_NARROW_LIMIT);
            wt     = grp_setting[CSR_GRP_A6][2:0];
         end else begin
            grp = (area < AREA_SPLIT) ? CSR_GRP_A5
                                      : CSR_GRP_A8 + CSR_INDEX_W'((area - 5'd7) >> 1);
            setting = grp_setting[grp];
            narrow  = setting[3];
            wt      = setting[2:0];
         end
         if (narrow) scaled = 5'(wt) * 5'(acc.width_bytes);
         else scaled = (acc.width_bytes == 4'd4) ? 5'(wt) * 5'd2 : 5'(wt);
         r.wait_cycles = scaled + ((acc.req_type == KIND_READ) ? 5'd1 : 5'd2);
      end
      return r;
   endfunction

   function automatic access_type random_access();
      access_type  acc;
      int unsigned pick;
      pick           = $urandom_range(0, 99);
      acc.req_type   = KIND_W'($urandom_range(0, 3));
      acc.address    = $urandom();
      // noise: any width, any alignment
      if (pick < 12) begin
         acc.width_bytes = WIDTH_W'($urandom_range(0, 15));
         return acc;
      end
      case ($urandom_range(0, 2))
         0: acc.width_bytes = 4'd1;
         1: acc.width_bytes = 4'd2;
         default: acc.width_bytes = 4'd4;
      endcase
      // steer towards the finer parts of the map
      if (pick < 35) acc.address[27:20] = 8'h00;
      else if (pick < 45) acc.address[27:20] = 8'h03;
      else if (pick < 70) acc.address[27:24] = 4'h0;
      if (acc.width_bytes == 4'd2) acc.address[0] = 1'b0;
      if (acc.width_bytes == 4'd4) acc.address[1:0] = 2'b00;
      return acc;
   endfunction

   task automatic send_access(input access_type acc, input result_type want);
      if (!steady && $urandom_range(0, 99) < 9) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= acc.req_type;
      req_tdata  <= {4'h0, acc.width_bytes, acc.address};
      do @(posedge clock); while (!req_tready);
      pending_decodes.push_back(want);
   endtask

   // drain, then write every index; indexes past the last group are ignored
   task automatic write_groups(input logic [CSR_DATA_W-1:0] fill, input bit scramble);
      logic [CSR_DATA_W-1:0] v;
      req_tvalid <= 1'b0;
      while (pending_decodes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      for (int i = 0; i < N_INDEXES; i++) begin
         v = scramble ? CSR_DATA_W'($urandom_range(0, 15)) : fill;
         csr_we    <= 1'b1;
         csr_index <= CSR_INDEX_W'(i);
         csr_wdata <= v;
         if (i < N_GROUPS)
            grp_setting[i] = (CSR_INDEX_W'(i) == CSR_GRP_A6) ? (v & 4'h7) : v;
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 9);
   end

   always @(posedge clock) begin
      result_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[11:0];
         if (pending_decodes.size() == 0) begin
            $display("%0t: unexpected result: area %0d wait %0d fault %0d", $time,
                     got.area_number, got.wait_cycles, got.fault_code);
            mismatches++;
         end else begin
            want = pending_decodes.pop_front();
            if (got.area_number !== want.area_number) begin
               $display("%0t: area_number expected %0d actual %0d", $time,
                        want.area_number, got.area_number);
               mismatches++;
            end
            if (got.wait_cycles !== want.wait_cycles) begin
               $display("%0t: wait_cycles expected %0d actual %0d", $time,
                        want.wait_cycles, got.wait_cycles);
               mismatches++;
            end
            if (got.fault_code !== want.fault_code) begin
               $display("%0t: fault_code expected %0d actual %0d", $time,
                        want.fault_code, got.fault_code);
               mismatches++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      access_type acc;
      result_type want;
      for (int g = 0; g < N_GROUPS; g++)
         grp_setting[g] = (CSR_INDEX_W'(g) == CSR_GRP_A6) ? 4'(GRP_WAIT_RESET) : GRP_CFG_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (probes[i]) begin
         acc.req_type    = probes[i].kind;
         acc.address     = probes[i].addr;
         acc.width_bytes = probes[i].width;
         want = probes[i].known ? probes[i].res : decode_access(acc);
         send_access(acc, want);
      end

      for (int p = 0; p < N_PHASES; p++) begin
         case (p)
            0: write_groups(4'h0, 1'b0);
            1: write_groups(4'hF, 1'b0);
            default: write_groups(4'h0, 1'b1);
         endcase
         steady = (p == 3);  // one phase with neither side holding off
         for (int n = 0; n < RANDOM_ACCESSES / N_PHASES; n++) begin
            acc = random_access();
            send_access(acc, decode_access(acc));
         end
      end
      steady = 1'b0;

      req_tvalid <= 1'b0;
      while (pending_decodes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
